[hdl/point_segment_distance_unit_assert.svh]
// assertion macros for the point to segment distance unit
`ifndef POINT_SEGMENT_DISTANCE_UNIT_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("psd assertion failed");
`define PSD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("psd reset assertion failed");
`else
`define PSD_ASSERT(lbl, prop)
`define PSD_ASSERT_RST(lbl, prop)
`endif
`endif

[hdl/psd_pkg.sv]
// types and constants of the point to segment distance unit
`default_nettype none
package psd_pkg;
  localparam int COORD_BITS  = 16;
  localparam int FRAC_BITS   = 8;
  localparam int DIST_BITS   = 25;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int MAG_W       = 2 * COORD_BITS + 1;
  localparam int CR_LO_W     = (MAG_W + 1) / 2;
  localparam int CR_HI_W     = MAG_W - CR_LO_W;
  localparam int CR2_W       = 2 * MAG_W;
  localparam int RAD_W       = 2 * DIST_BITS;
  localparam int NUM_W       = CR2_W + 2 * FRAC_BITS;
  localparam int REM_W       = MAG_W + 1;
  localparam int SQR_W       = DIST_BITS + 3;
  localparam int IN_W        = 6 * COORD_BITS;
  localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIST_BITS + 7) / 8) * 8;
  localparam int PRE_STAGES  = 5;
  localparam int DIV_STAGES  = RAD_W;
  localparam int SQRT_STAGES = DIST_BITS;
  localparam int TOTAL_STAGES = PRE_STAGES + DIV_STAGES + SQRT_STAGES;

  typedef enum logic [1:0] {
    REGION_BEYOND_B = 2'd0,
    REGION_BEFORE_A = 2'd1,
    REGION_PERP     = 2'd2,
    REGION_DEGEN    = 2'd3
  } region_t;
endpackage
`default_nettype wire

[hdl/point_segment_distance_unit.sv]
// point to segment distance unit: 80-stage pipeline, one word per cycle
//
// in_tdata carries the segment endpoints a, b and the query point p as
// signed 16-bit coordinates; out_tdata carries the distance as unsigned
// fixed point with 8 fraction bits (truncated), out_tuser the region code
// (beyond b, before a, perpendicular, degenerate segment).
// one word is accepted on every cycle that in_tvalid and in_tready are high,
// and the words come out in order. the pipeline has stages for differences,
// products, region decision, cross partial products and numerator assembly,
// then 50 restoring division steps for the squared perpendicular distance,
// and 25 square root steps, one bit per stage; this chain sets the latency.
// a synchronous reset (rst_n low) empties the pipeline; no words are held.
// when out_tready is low with a word waiting, the whole pipeline holds and
// in_tready drops, so nothing is lost or repeated; bubbles are not squeezed out.
`default_nettype none
`include "point_segment_distance_unit_assert.svh"
module point_segment_distance_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // a_x, a_y, b_x, b_y, p_x, p_y
  input  wire logic [psd_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // distance, zero fill
  output logic [psd_pkg::OUT_TDATA_W-1:0]         out_tdata,
  // region
  output logic [1:0]                              out_tuser
);
  localparam int CW = psd_pkg::COORD_BITS;
  localparam int DW = psd_pkg::DIFF_W;
  localparam int PW = psd_pkg::PROD_W;
  localparam int SW = psd_pkg::SUM_W;
  localparam int MW = psd_pkg::MAG_W;
  localparam int LOW = psd_pkg::CR_LO_W;
  localparam int HIW = psd_pkg::CR_HI_W;
  localparam int C2W = psd_pkg::CR2_W;
  localparam int RW = psd_pkg::RAD_W;
  localparam int NW = psd_pkg::NUM_W;
  localparam int EW = psd_pkg::REM_W;
  localparam int QW = psd_pkg::SQR_W;
  localparam int OW = psd_pkg::DIST_BITS;
  localparam int FB = psd_pkg::FRAC_BITS;
  localparam int NDIV = psd_pkg::DIV_STAGES;
  localparam int NSQ = psd_pkg::SQRT_STAGES;
  localparam int NPRE = psd_pkg::PRE_STAGES;
  localparam int NTOT = psd_pkg::TOTAL_STAGES;

  logic            en;
  logic [NTOT-1:0] vld_r;
  logic [NTOT-1:0] vld_nxt;

  assign en        = !vld_r[NTOT-1] || out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[NTOT-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // stage a: differences
  logic signed [CW-1:0] ax, ay, bx, by, px, py;
  logic signed [DW-1:0] abx_r, aby_r, apx_r, apy_r, bpx_r, bpy_r;
  logic signed [DW-1:0] abx_nxt, aby_nxt, apx_nxt, apy_nxt, bpx_nxt, bpy_nxt;
  logic                 deg_a_r, deg_a_nxt;

  always_comb begin
    ax = signed'(in_tdata[0*CW +: CW]);
    ay = signed'(in_tdata[1*CW +: CW]);
    bx = signed'(in_tdata[2*CW +: CW]);
    by = signed'(in_tdata[3*CW +: CW]);
    px = signed'(in_tdata[4*CW +: CW]);
    py = signed'(in_tdata[5*CW +: CW]);
    abx_nxt = DW'(bx) - DW'(ax);
    aby_nxt = DW'(by) - DW'(ay);
    apx_nxt = DW'(px) - DW'(ax);
    apy_nxt = DW'(py) - DW'(ay);
    bpx_nxt = DW'(px) - DW'(bx);
    bpy_nxt = DW'(py) - DW'(by);
    deg_a_nxt = (ax == bx) && (ay == by);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx_r <= abx_nxt;
      aby_r <= aby_nxt;
      apx_r <= apx_nxt;
      apy_r <= apy_nxt;
      bpx_r <= bpx_nxt;
      bpy_r <= bpy_nxt;
      deg_a_r <= deg_a_nxt;
    end
  end

  // stage b: products
  logic signed [PW-1:0] db1_r, db2_r, da1_r, da2_r, cr1_r, cr2_r;
  logic signed [PW-1:0] sa1_r, sa2_r, sb1_r, sb2_r, sl1_r, sl2_r;
  logic signed [PW-1:0] db1_nxt, db2_nxt, da1_nxt, da2_nxt, cr1_nxt, cr2_nxt;
  logic signed [PW-1:0] sa1_nxt, sa2_nxt, sb1_nxt, sb2_nxt, sl1_nxt, sl2_nxt;
  logic                 deg_b_r;

  always_comb begin
    db1_nxt = abx_r * bpx_r;
    db2_nxt = aby_r * bpy_r;
    da1_nxt = abx_r * apx_r;
    da2_nxt = aby_r * apy_r;
    cr1_nxt = abx_r * apy_r;
    cr2_nxt = aby_r * apx_r;
    sa1_nxt = apx_r * apx_r;
    sa2_nxt = apy_r * apy_r;
    sb1_nxt = bpx_r * bpx_r;
    sb2_nxt = bpy_r * bpy_r;
    sl1_nxt = abx_r * abx_r;
    sl2_nxt = aby_r * aby_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      db1_r <= db1_nxt;
      db2_r <= db2_nxt;
      da1_r <= da1_nxt;
      da2_r <= da2_nxt;
      cr1_r <= cr1_nxt;
      cr2_r <= cr2_nxt;
      sa1_r <= sa1_nxt;
      sa2_r <= sa2_nxt;
      sb1_r <= sb1_nxt;
      sb2_r <= sb2_nxt;
      sl1_r <= sl1_nxt;
      sl2_r <= sl2_nxt;
      deg_b_r <= deg_a_r;
    end
  end

  // stage c: region decision, cross magnitude, squared lengths
  logic signed [SW-1:0] dotb, dota, crs, sqa, sqb, len2;
  logic [SW-1:0]        crs_abs;
  psd_pkg::region_t     reg_c_r, reg_c_nxt;
  logic [MW-1:0]        sq_c_r, sq_c_nxt, cr_c_r, cr_c_nxt, len_c_r, len_c_nxt;

  always_comb begin
    dotb = SW'(db1_r) + SW'(db2_r);
    dota = SW'(da1_r) + SW'(da2_r);
    crs  = SW'(cr1_r) - SW'(cr2_r);
    sqa  = SW'(sa1_r) + SW'(sa2_r);
    sqb  = SW'(sb1_r) + SW'(sb2_r);
    len2 = SW'(sl1_r) + SW'(sl2_r);
    crs_abs = crs[SW-1] ? SW'(-crs) : SW'(crs);
    priority if (deg_b_r) begin
      reg_c_nxt = psd_pkg::REGION_DEGEN;
    end else if (dotb > 0) begin
      reg_c_nxt = psd_pkg::REGION_BEYOND_B;
    end else if (dota < 0) begin
      reg_c_nxt = psd_pkg::REGION_BEFORE_A;
    end else begin
      reg_c_nxt = psd_pkg::REGION_PERP;
    end
    sq_c_nxt  = (reg_c_nxt == psd_pkg::REGION_BEYOND_B) ? sqb[MW-1:0] : sqa[MW-1:0];
    cr_c_nxt  = crs_abs[MW-1:0];
    len_c_nxt = len2[MW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reg_c_r <= reg_c_nxt;
      sq_c_r  <= sq_c_nxt;
      cr_c_r  <= cr_c_nxt;
      len_c_r <= len_c_nxt;
    end
  end

  // stage d: partial products of the cross magnitude squared
  logic [2*HIW-1:0]     hh_r, hh_nxt;
  logic [HIW+LOW-1:0]   hl_r, hl_nxt;
  logic [2*LOW-1:0]     ll_r, ll_nxt;
  psd_pkg::region_t     reg_d_r;
  logic [MW-1:0]        sq_d_r, len_d_r;

  always_comb begin
    hh_nxt = cr_c_r[MW-1:LOW] * cr_c_r[MW-1:LOW];
    hl_nxt = cr_c_r[MW-1:LOW] * cr_c_r[LOW-1:0];
    ll_nxt = cr_c_r[LOW-1:0] * cr_c_r[LOW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hh_r    <= hh_nxt;
      hl_r    <= hl_nxt;
      ll_r    <= ll_nxt;
      reg_d_r <= reg_c_r;
      sq_d_r  <= sq_c_r;
      len_d_r <= len_c_r;
    end
  end

  // stage e: numerator assembly, divider seed
  logic [C2W-1:0] crsq;
  logic [NW-1:0]  num;
  logic [EW-1:0]  rem_e_nxt;
  logic [RW-1:0]  nlo_e_nxt;

  always_comb begin
    crsq = (C2W'(hh_r) << (2 * LOW)) + (C2W'(hl_r) << (LOW + 1)) + C2W'(ll_r);
    num  = NW'(crsq) << (2 * FB);
    rem_e_nxt = EW'(num[NW-1:RW]);
    nlo_e_nxt = num[RW-1:0];
  end

  // divider: one quotient bit per stage, index 0 is the seed
  logic [NDIV:0][EW-1:0] drem_r;
  logic [NDIV:0][RW-1:0] dnlo_r;
  logic [NDIV:0][RW-1:0] dquo_r;
  logic [NDIV:0][MW-1:0] dsq_r;
  logic [NDIV:0][MW-1:0] dlen_r;
  psd_pkg::region_t      dreg_r [NDIV+1];

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0] <= rem_e_nxt;
      dnlo_r[0] <= nlo_e_nxt;
      dquo_r[0] <= '0;
      dsq_r[0]  <= sq_d_r;
      dlen_r[0] <= len_d_r;
      dreg_r[0] <= reg_d_r;
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [EW-1:0] trial;
    logic          ge;
    logic [EW-1:0] rem_nxt;

    always_comb begin
      trial   = {drem_r[k][EW-2:0], dnlo_r[k][RW-1]};
      ge      = trial >= EW'(dlen_r[k]);
      rem_nxt = ge ? (trial - EW'(dlen_r[k])) : trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem_r[k+1] <= rem_nxt;
        dnlo_r[k+1] <= {dnlo_r[k][RW-2:0], 1'b0};
        dquo_r[k+1] <= {dquo_r[k][RW-2:0], ge};
        dsq_r[k+1]  <= dsq_r[k];
        dlen_r[k+1] <= dlen_r[k];
        dreg_r[k+1] <= dreg_r[k];
      end
    end
  end

  // square root: one result bit per stage
  logic [NSQ:0][QW-1:0] srem;
  logic [NSQ:0][OW-1:0] sroot;
  logic [NSQ:0][RW-1:0] srad;
  psd_pkg::region_t     sreg [NSQ+1];

  always_comb begin
    srem[0]  = '0;
    sroot[0] = '0;
    srad[0]  = (dreg_r[NDIV] == psd_pkg::REGION_PERP) ? dquo_r[NDIV]
             : (RW'(dsq_r[NDIV]) << (2 * FB));
    sreg[0]  = dreg_r[NDIV];
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    logic [QW-1:0] rem_nxt_r, rem_sh, trial;
    logic [OW-1:0] root_r;
    logic [RW-1:0] rad_r;
    logic          ge;
    psd_pkg::region_t reg_r;

    always_comb begin
      rem_sh = {srem[j][QW-3:0], srad[j][RW-1:RW-2]};
      trial  = QW'({sroot[j], 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_nxt_r <= ge ? (rem_sh - trial) : rem_sh;
        root_r    <= {sroot[j][OW-2:0], ge};
        rad_r     <= {srad[j][RW-3:0], 2'b00};
        reg_r     <= sreg[j];
      end
    end

    always_comb begin
      srem[j+1]  = rem_nxt_r;
      sroot[j+1] = root_r;
      srad[j+1]  = rad_r;
      sreg[j+1]  = reg_r;
    end
  end

  assign out_tvalid = vld_r[NTOT-1];
  assign out_tdata  = psd_pkg::OUT_TDATA_W'(sroot[NSQ]);
  assign out_tuser  = sreg[NSQ];

  `PSD_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid)
  `PSD_ASSERT(a_empty_ready, !out_tvalid |-> in_tready)
  `PSD_ASSERT(a_enter_moves, (in_tvalid && in_tready) |=> vld_r[0])
  `PSD_ASSERT(a_hold_out, (out_tvalid && !out_tready) |=> $stable(vld_r))
endmodule
`default_nettype wire

[dv/point_segment_distance_checker.sv]
// checker for the point to segment distance unit: watches both streams, predicts and compares
`timescale 1ns / 1ps
module point_segment_distance_checker
  import psd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  input  wire logic                   in_tready,
  // a_x, a_y, b_x, b_y, p_x, p_y
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                   out_tvalid,
  input  wire logic                   out_tready,
  // distance, zero fill
  input  wire logic [OUT_TDATA_W-1:0] out_tdata,
  // region
  input  wire logic [1:0]             out_tuser,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [DIST_BITS-1:0] distance;
    region_t              region;
  } dist_word_t;

  dist_word_t expected_words[$];

  // largest q below 2^DIST_BITS with q*q*den <= num
  function automatic logic [DIST_BITS-1:0] root_of_ratio(logic [127:0] num, logic [127:0] den);
    logic [DIST_BITS-1:0] q;
    logic [DIST_BITS-1:0] c;
    logic [127:0] prod;
    q = '0;
    for (int b = DIST_BITS - 1; b >= 0; b--) begin
      c = q | (1 << b);
      prod = 128'(c) * 128'(c) * den;
      if (prod <= num) q = c;
    end
    return q;
  endfunction

  function automatic dist_word_t predict_distance(logic [IN_TDATA_W-1:0] w);
    longint ax, ay, bx, by, px, py;
    longint abx, aby, apx, apy, bpx, bpy, cr;
    dist_word_t r;
    ax = longint'($signed(w[0*COORD_BITS +: COORD_BITS]));
    ay = longint'($signed(w[1*COORD_BITS +: COORD_BITS]));
    bx = longint'($signed(w[2*COORD_BITS +: COORD_BITS]));
    by = longint'($signed(w[3*COORD_BITS +: COORD_BITS]));
    px = longint'($signed(w[4*COORD_BITS +: COORD_BITS]));
    py = longint'($signed(w[5*COORD_BITS +: COORD_BITS]));
    abx = bx - ax; aby = by - ay;
    apx = px - ax; apy = py - ay;
    bpx = px - bx; bpy = py - by;
    if (abx == 0 && aby == 0) begin
      r.distance = root_of_ratio(128'(apx * apx + apy * apy) << (2 * FRAC_BITS), 128'd1);
      r.region = REGION_DEGEN;
    end else if (abx * bpx + aby * bpy > 0) begin
      r.distance = root_of_ratio(128'(bpx * bpx + bpy * bpy) << (2 * FRAC_BITS), 128'd1);
      r.region = REGION_BEYOND_B;
    end else if (abx * apx + aby * apy < 0) begin
      r.distance = root_of_ratio(128'(apx * apx + apy * apy) << (2 * FRAC_BITS), 128'd1);
      r.region = REGION_BEFORE_A;
    end else begin
      cr = abx * apy - aby * apx;
      if (cr < 0) cr = -cr;
      r.distance = root_of_ratio((128'(cr) * 128'(cr)) << (2 * FRAC_BITS),
                                 128'(abx * abx + aby * aby));
      r.region = REGION_PERP;
    end
    return r;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    dist_word_t exp_w;
    int fails;
    fails = 0;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_words.push_back(predict_distance(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word distance=%0d region=%0d", $time,
                   out_tdata[DIST_BITS-1:0], out_tuser);
          fails++;
        end else begin
          exp_w = expected_words.pop_front();
          if (out_tdata !== OUT_TDATA_W'(exp_w.distance)) begin
            $display("%0t: distance expected %0d actual %0d", $time, exp_w.distance, out_tdata);
            fails++;
          end
          if (out_tuser !== exp_w.region) begin
            $display("%0t: region expected %0d actual %0d", $time, exp_w.region, out_tuser);
            fails++;
          end
        end
      end
      if (fails != 0) errors <= errors + fails;
    end
  end

endmodule

[dv/point_segment_distance_unit_tb.sv]
// testbench top for the point to segment distance unit: stimulus, stalls and verdict
`timescale 1ns / 1ps
module point_segment_distance_unit_tb;
  import psd_pkg::*;

  localparam int RANDOM_WORDS = 1000;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  int errors, pending;
  int sent_words = 0;
  int cycles = 0;

  always #2 clk = ~clk;

  point_segment_distance_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  point_segment_distance_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off while the sender keeps going
  initial begin
    bit held;
    int mode;
    held = 0;
    forever begin
      @(posedge clk);
      if (!held && sent_words >= 300) begin
        held = 1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode = (cycles / 150) % 3;
      if (mode == 0) out_tready <= 1'b1;
      else if (mode == 1) out_tready <= ($urandom_range(0, 3) != 0);
      else out_tready <= ($urandom_range(0, 1) != 0);
    end
  end

  int burst_left = 0;

  task automatic send_word(logic signed [15:0] ax, ay, bx, by, px, py);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 1)) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {py, px, by, bx, ay, ax};
    do @(posedge clk); while (!in_tready);
    sent_words++;
  endtask

  function automatic logic signed [15:0] rand_coord(int span);
    if (span >= 32768) return 16'($urandom);
    return 16'($urandom_range(0, 2 * span) - span);
  endfunction

  initial begin
    int kind, span;
    logic signed [15:0] ax, ay, bx, by, px, py;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes, each region, degenerate segment and the region boundaries
    send_word(-32768, -32768, 32767, 32767, -32768, 32767);
    send_word(-32768, -32768, -32768, -32768, 32767, 32767);
    send_word(32767, 32767, 32767, 32767, -32768, -32768);
    send_word(0, 0, 0, 0, 0, 0);
    send_word(-32768, 32767, 32767, -32768, 32767, 32767);
    send_word(32767, -32768, -32768, 32767, -32768, -32768);
    send_word(-32768, 0, 32767, 0, 0, 32767);
    send_word(0, 0, 10, 0, 15, 3);
    send_word(0, 0, 10, 0, -5, 4);
    send_word(0, 0, 10, 0, 5, -7);
    send_word(0, 0, 10, 0, 10, 9);
    send_word(0, 0, 10, 0, 0, -9);
    send_word(0, 0, 10, 0, 5, 0);
    send_word(3, 4, 3, 4, 0, 0);
    send_word(0, 0, 1, 1, 1, 0);
    send_word(-32768, -32768, 32767, 32767, 32767, 32767);
    send_word(-32768, -32768, 32767, 32767, 32767, -32768);
    send_word(0, 0, 0, 32767, 32767, 16000);
    send_word(-1, -1, 1, 1, -1, 1);
    send_word(32767, 0, -32768, 0, 0, -32768);
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      kind = $urandom_range(0, 9);
      span = (kind < 4) ? 8 : (kind < 7) ? 1000 : 32768;
      ax = rand_coord(span); ay = rand_coord(span);
      bx = rand_coord(span); by = rand_coord(span);
      px = rand_coord(span); py = rand_coord(span);
      if (kind == 0 && $urandom_range(0, 2) == 0) begin
        bx = ax; by = ay;
      end
      send_word(ax, ay, bx, by, px, py);
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
